@@ sv/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg: shared types for the heap sort engine
// Word formats of the input and result channels.
// ----------------------------------------------------------------------------
package hse_pkg;

    localparam int unsigned VALUE_W = 32;

    // One input word: an element of the run and the end-of-run flag.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_word;

    // One result word: the next element in ascending order.
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_res;
        logic                      truncated;
    } t_out_word;

endpackage

@@ sv/heap_sort_engine.sv @@
// ----------------------------------------------------------------------------
// heap_sort_engine: in-memory heap sort of one run of signed values
// Loads a run into a RAM, heapifies it, extracts it and streams it out sorted.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake               Word
// --------  ---------  ----------------------  ---------------------------
// input     in         start high, busy low    i_word (value, last)
// result    out        o_strobe, one cycle     o_word (sorted_value,
//                                              last_res, truncated)
//
// Loading accepts one word in each cycle that start is high; busy stays low
// until the word that carries last is accepted. The sort then runs entirely
// out of the value RAM: each sift-down level reads both children, then
// compares and writes back, for each of the n/2 heapify and n-1 extraction
// passes of a run of n elements, and the results are then streamed out. The
// registered read of the RAM sets this pace. The results leave back to back,
// behind their reads through the RAM read register and the o_word register,
// and busy falls as the last read is issued, so a new run may load while
// the tail of the previous one is still being delivered.
// Reset is synchronous and active low; it clears the element count, the
// overflow flag and the control state. The RAM is not cleared: only entries
// written in the current run are ever read. The receiver cannot stall.
//
module heap_sort_engine
    import hse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_word
);

    localparam int AW  = $clog2(DEPTH);     // RAM address width
    localparam int CW  = $clog2(DEPTH + 1); // element count width
    localparam int CHW = AW + 2;            // child index width

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // The sequencer walks through heapify, extraction and output phases.
    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD_RD,
        S_BUILD_LD,
        S_SD_RD,
        S_SD_CMP,
        S_SWAP_RD,
        S_SWAP_WR,
        S_OUT
    } t_state;

    t_state r_state;

    logic [CW-1:0]             r_count;  // elements stored in this run
    logic                      r_ovf;    // a word was dropped in this run
    logic [CW-1:0]             r_i;      // heapify parent+1, or heap size
    logic                      r_build;  // sift belongs to the heapify phase
    logic [AW-1:0]             r_node;   // current hole of the sift-down
    logic [CW-1:0]             r_len;    // heap length of the sift-down
    logic signed [VALUE_W-1:0] r_v;      // value being sifted down
    logic [AW-1:0]             r_k;      // output read index
    logic                      r_rd_vld;
    logic                      r_rd_last;
    logic                      r_rd_trunc;

    // RAM interface.
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [VALUE_W-1:0]        mem_wdata;
    logic [AW-1:0]             mem_raddr_a;
    logic [AW-1:0]             mem_raddr_b;
    logic [VALUE_W-1:0]        mem_rdata_a;
    logic [VALUE_W-1:0]        mem_rdata_b;
    logic signed [VALUE_W-1:0] rd_a;
    logic signed [VALUE_W-1:0] rd_b;

    assign rd_a = mem_rdata_a;
    assign rd_b = mem_rdata_b;

    hse_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // Child indexes of the current hole and their validity within the heap.
    logic [CHW-1:0] w_lc;
    logic [CHW-1:0] w_rc;
    logic           w_lc_ok;
    logic           w_rc_ok;
    logic [CW-1:0]  w_im1;

    assign w_lc    = CHW'({r_node, 1'b1});
    assign w_rc    = w_lc + CHW'(1);
    assign w_lc_ok = w_lc < CHW'(r_len);
    assign w_rc_ok = w_rc < CHW'(r_len);
    assign w_im1   = r_i - CW'(1);

    // The hole always holds r_v, so only the children need comparing. The
    // left child wins over the hole on strictly greater, the right child wins
    // over that result on strictly greater, as in a swap-based sift-down.
    logic                      w_lc_gt;
    logic signed [VALUE_W-1:0] w_cand;
    logic                      w_rc_gt;
    logic                      w_move;
    logic signed [VALUE_W-1:0] w_big_val;
    logic [AW-1:0]             w_big_idx;

    assign w_lc_gt   = rd_a > r_v;
    assign w_cand    = w_lc_gt ? rd_a : r_v;
    assign w_rc_gt   = w_rc_ok && (rd_b > w_cand);
    assign w_move    = w_lc_gt || w_rc_gt;
    assign w_big_val = w_rc_gt ? rd_b : rd_a;
    assign w_big_idx = w_rc_gt ? w_rc[AW-1:0] : w_lc[AW-1:0];

    // Run length once the current input word is counted.
    logic          w_room;
    logic [CW-1:0] w_n_load;
    logic          w_k_last;

    assign w_room   = r_count < DEPTH_C;
    assign w_n_load = w_room ? r_count + CW'(1) : r_count;
    assign w_k_last = (CW'(r_k) + CW'(1)) == r_count;

    // After a sift-down the heapify phase moves on to the next parent and the
    // extraction phase to the next swap.
    t_state w_after_sift;

    assign w_after_sift = r_build ? S_BUILD_RD : S_SWAP_RD;

    // RAM port steering. Reads and writes never meet on one entry in the
    // same cycle: every write lands before the read that depends on it is
    // issued, since a sift only ever reads below the hole it just filled.
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_v;
        mem_raddr_a = w_lc[AW-1:0];
        mem_raddr_b = w_rc_ok ? w_rc[AW-1:0] : w_lc[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                mem_we    = start && w_room;
                mem_waddr = r_count[AW-1:0];
                mem_wdata = i_word.value;
            end
            S_BUILD_RD: begin
                mem_raddr_a = w_im1[AW-1:0];
            end
            S_BUILD_LD: begin
            end
            S_SD_RD: begin
                // No children left: drop the sifted value into the hole.
                mem_we = !w_lc_ok;
            end
            S_SD_CMP: begin
                mem_we    = 1'b1;
                mem_wdata = w_move ? w_big_val : r_v;
            end
            S_SWAP_RD: begin
                mem_raddr_a = '0;
                mem_raddr_b = w_im1[AW-1:0];
            end
            S_SWAP_WR: begin
                // The old root goes to the end of the heap; the old last
                // element is sifted down from the root.
                mem_we    = 1'b1;
                mem_waddr = w_im1[AW-1:0];
                mem_wdata = rd_a;
            end
            S_OUT: begin
                mem_raddr_a = r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_rd_vld   <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_OUT);
            o_strobe <= r_rd_vld;
            if (r_rd_vld) begin
                o_word.sorted_value <= rd_a;
                o_word.last_res     <= r_rd_last;
                o_word.truncated    <= r_rd_trunc;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (w_room) begin
                            r_count <= w_n_load;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_word.last) begin
                            r_i     <= w_n_load >> 1;
                            r_build <= 1'b1;
                            r_state <= S_BUILD_RD;
                        end
                    end
                end
                S_BUILD_RD: begin
                    if (r_i == '0) begin
                        r_i     <= r_count;
                        r_build <= 1'b0;
                        r_state <= S_SWAP_RD;
                    end else begin
                        r_state <= S_BUILD_LD;
                    end
                end
                S_BUILD_LD: begin
                    r_v     <= rd_a;
                    r_node  <= w_im1[AW-1:0];
                    r_len   <= r_count;
                    r_state <= S_SD_RD;
                end
                S_SD_RD: begin
                    if (w_lc_ok) begin
                        r_state <= S_SD_CMP;
                    end else begin
                        if (r_build) begin
                            r_i <= w_im1;
                        end
                        r_state <= w_after_sift;
                    end
                end
                S_SD_CMP: begin
                    if (w_move) begin
                        r_node  <= w_big_idx;
                        r_state <= S_SD_RD;
                    end else begin
                        if (r_build) begin
                            r_i <= w_im1;
                        end
                        r_state <= w_after_sift;
                    end
                end
                S_SWAP_RD: begin
                    if (r_i <= CW'(1)) begin
                        r_k     <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SWAP_WR;
                    end
                end
                S_SWAP_WR: begin
                    r_v     <= rd_b;
                    r_node  <= '0;
                    r_len   <= w_im1;
                    r_i     <= w_im1;
                    r_state <= S_SD_RD;
                end
                S_OUT: begin
                    r_rd_last  <= w_k_last;
                    r_rd_trunc <= r_ovf;
                    r_k        <= r_k + AW'(1);
                    if (w_k_last) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ sv/hse_ram.sv @@
// ----------------------------------------------------------------------------
// hse_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ sv/hse_checker.sv @@
// ----------------------------------------------------------------------------
// hse_checker: port-level checks for the heap sort engine
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module hse_checker
    import hse_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input t_in_word  i_word,
    input logic      busy,
    input logic      o_strobe,
    input t_out_word o_word
);

    // Reset leaves the engine idle with no result on the ports.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("engine not quiet after reset");

    // The word that ends a run always starts the sort.
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_word.last |=> busy)
        else $error("final word did not start the sort");

    // Results of one run leave back to back until the one marked last.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_word.last_res |=> o_strobe)
        else $error("gap inside a sorted run");

    // Within a run, results come in ascending order with one truncated flag.
    a_run_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && $past(o_strobe) && !$past(o_word.last_res) |->
        (o_word.sorted_value >= $past(o_word.sorted_value)) &&
        (o_word.truncated == $past(o_word.truncated)))
        else $error("sorted run out of order or truncated flag changed");

endmodule

bind heap_sort_engine hse_checker u_hse_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_word   (i_word),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_word   (o_word)
);

@@ dv/heap_sort_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_sort_engine_test: self-checking bench for the heap sort engine
// Sends runs of signed words, predicts the ascending output of every run and
// compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module heap_sort_engine_test;
    import hse_pkg::*;

    localparam int DEPTH     = 64;
    localparam int CLK_HALF  = 10;
    localparam int RAND_WORDS = 500;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // ------------------------------------------------------------------------
    // Scoreboard: collects the words of the run being loaded and, when the
    // word that closes the run is accepted, queues the run in ascending order.
    // The order of equal values is not visible, so a plain sort suffices.
    // ------------------------------------------------------------------------
    class sort_scoreboard;
        int                        store_depth;
        int                        errors;
        logic signed [VALUE_W-1:0] run_vals[$];
        bit                        run_overflow;
        t_out_word                 sorted_words_q[$];

        function new(int depth);
            store_depth  = depth;
            errors       = 0;
            run_overflow = 1'b0;
        endfunction

        function int pending();
            return sorted_words_q.size();
        endfunction

        // Called for every word the block accepts.
        function void note_word(t_in_word w);
            logic signed [VALUE_W-1:0] ordered[$];
            t_out_word                 res;
            int                        pos;
            if (run_vals.size() < store_depth) begin
                run_vals.push_back(w.value);
            end else begin
                // Store full: the word is dropped, the run is marked.
                run_overflow = 1'b1;
            end
            if (!w.last) begin
                return;
            end
            // Insertion sort into ascending order.
            foreach (run_vals[i]) begin
                pos = 0;
                while (pos < ordered.size() && ordered[pos] <= run_vals[i]) begin
                    pos++;
                end
                ordered.insert(pos, run_vals[i]);
            end
            foreach (ordered[k]) begin
                res.sorted_value = ordered[k];
                res.last_res     = (k == ordered.size() - 1);
                res.truncated    = run_overflow;
                sorted_words_q.push_back(res);
            end
            run_vals.delete();
            run_overflow = 1'b0;
        endfunction

        // Called for every result word the block strobes out.
        function void check_word(t_out_word got);
            t_out_word exp;
            if (sorted_words_q.size() == 0) begin
                $error("result word with no expected word pending: value %0d",
                       got.sorted_value);
                errors++;
                return;
            end
            exp = sorted_words_q.pop_front();
            if (got.sorted_value !== exp.sorted_value) begin
                $error("sorted_value: expected %0d, got %0d",
                       exp.sorted_value, got.sorted_value);
                errors++;
            end
            if (got.last_res !== exp.last_res) begin
                $error("last_res: expected %0b, got %0b", exp.last_res, got.last_res);
                errors++;
            end
            if (got.truncated !== exp.truncated) begin
                $error("truncated: expected %0b, got %0b", exp.truncated, got.truncated);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_word  i_word;
    logic      busy;
    logic      o_strobe;
    t_out_word o_word;

    sort_scoreboard sb;

    // Percentage of word slots in which the sender holds start low.
    int unsigned idle_pct;
    int unsigned words_sent;

    // Values of the run that send_run delivers next.
    logic signed [VALUE_W-1:0] run_buf[$];

    heap_sort_engine #(
        .DEPTH (DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_word   (i_word),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_word   (o_word)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // Safety net: far beyond the slowest correct run.
    initial begin
        #(64'd20_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Monitors. Inputs change on the falling edge only, so at the rising edge
    // start, i_word and the block's outputs all hold their settled values.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            sb.note_word(i_word);
        end
        if (i_rst_n && o_strobe) begin
            sb.check_word(o_word);
        end
    end

    // Random content for a value: mostly full-range, with bursts of small
    // values to force ties and some values at or near the two extremes.
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0, 1:    return $signed($urandom_range(16)) - 8;
            2:       return VAL_MIN + $urandom_range(3);
            3:       return VAL_MAX - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // Present one word and hold it until the block takes it. While the
    // sender idles, i_word carries noise that must be ignored.
    task automatic drive_word(input t_in_word w);
        t_in_word noise;
        while ($urandom_range(99) < idle_pct) begin
            noise.value = $urandom;
            noise.last  = $urandom_range(1);
            @(negedge i_clk);
            start  <= 1'b0;
            i_word <= noise;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_word <= w;
        do begin
            @(posedge i_clk);
        end while (busy);
        words_sent++;
    endtask

    // Deliver run_buf as one run; the final word carries last.
    task automatic send_run();
        t_in_word w;
        foreach (run_buf[i]) begin
            w.value = run_buf[i];
            w.last  = (i == run_buf.size() - 1);
            drive_word(w);
        end
    endtask

    // Pause the sender until every predicted result word has arrived.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned run_len;
        int unsigned target;

        sb         = new(DEPTH);
        idle_pct   = 12;
        words_sent = 0;
        start      = 1'b0;
        i_word     = '0;
        i_rst_n    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed runs. A run of a single word at each extreme.
        run_buf = '{VAL_MIN};
        send_run();
        run_buf = '{VAL_MAX};
        send_run();
        // Two words in descending order.
        run_buf = '{VAL_MAX, VAL_MIN};
        send_run();
        // Zero, the neighbors of zero and both extremes with their neighbors.
        run_buf = '{0, -1, 1, VAL_MAX, VAL_MIN, VAL_MAX - 1, VAL_MIN + 1};
        send_run();
        // Equal values must come out next to each other.
        run_buf = '{7, 7, -7, 7, 7};
        send_run();
        // Already in descending order, which is already a valid heap.
        run_buf = '{40, 30, 20, 10, 0, -10};
        send_run();
        drain();

        // Random runs in three phases: light sender idling, heavy idling,
        // then none. Most runs are short; some fill the store exactly and
        // some overrun it, so the truncated flag and the dropped final word
        // are exercised in every phase.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       idle_pct = 12;
                1:       idle_pct = 65;
                default: idle_pct = 0;
            endcase
            target = words_sent + RAND_WORDS / 3;
            while (words_sent < target) begin
                case ($urandom_range(19))
                    0, 1:    run_len = $urandom_range(DEPTH + 6, DEPTH - 4);
                    2:       run_len = DEPTH;
                    3, 4, 5: run_len = $urandom_range(40, 13);
                    default: run_len = $urandom_range(12, 1);
                endcase
                run_buf.delete();
                repeat (run_len) begin
                    run_buf.push_back(rand_value());
                end
                send_run();
            end
            // The sender waits for the block to empty before moving on.
            drain();
        end

        // Allow for any stray words after the last expected one.
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/hse_pkg.sv
sv/hse_ram.sv
sv/heap_sort_engine.sv
sv/hse_checker.sv
dv/heap_sort_engine_test.sv
